[rtl/fds_pkg.sv]
package fds_pkg;

    localparam int PCT_W    = 7;
    localparam int STATE_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0] OFF_LEVEL  = 7'd5;
    localparam logic [PCT_W:0]   ON_MARGIN  = 8'd10;

    localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [STATE_W-1:0] ST_RAMP   = 3'd1;
    localparam logic [STATE_W-1:0] ST_BOOST  = 3'd2;
    localparam logic [STATE_W-1:0] ST_SAFETY = 3'd3;
    localparam logic [STATE_W-1:0] ST_OTHER  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MODE = 2'd2;

    localparam logic [PCT_W-1:0] CLAMP_MIN_RST = 7'd20;
    localparam logic [PCT_W-1:0] CLAMP_MAX_RST = 7'd100;

    typedef struct packed {
        logic [PCT_W-1:0]   smoothed;
        logic               enabled;
        logic [STATE_W-1:0] prev_state;
    } fds_state_t;

    typedef struct packed {
        logic [PCT_W-1:0] clamp_min;
        logic [PCT_W-1:0] clamp_max;
        logic             clamp_mode;
    } fds_cfg_t;

    function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
        sat_pct = (v > PCT_FULL) ? PCT_FULL : v;
    endfunction

endpackage

[rtl/fan_demand_shaper_unit.sv]
// Fan demand shaper. Takes one word per cycle while s_tready is high (burn
// state and raw demand percent) and returns one fan percent word per input
// word, in order. An input word is registered, shaped by a single
// combinational pass that also updates the smoother state, and lands in
// the output register that drives m_tvalid. Throughput is one word per
// clock while m_tready stays high. Configuration writes are always taken
// (cfg_ready is tied high) and should only be issued while no word is in
// flight.
module fan_demand_shaper_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // [2:0] burn_state, [9:3] demand
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // [6:0] fan_percent
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fds_pkg::PCT_W-1:0]     cfg_data
);
    import fds_pkg::*;

    fds_cfg_t           cfg_reg;
    fds_state_t         state_reg;
    fds_state_t         state_next;
    logic               in_valid_reg;
    logic [STATE_W-1:0] in_state_reg;
    logic [PCT_W-1:0]   in_demand_reg;
    logic               out_valid_reg;
    logic [PCT_W-1:0]   out_pct_reg;
    logic [PCT_W-1:0]   fan_next;
    logic               out_adv;
    logic               in_adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clamp_min  <= CLAMP_MIN_RST;
            cfg_reg.clamp_max  <= CLAMP_MAX_RST;
            cfg_reg.clamp_mode <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CLAMP_MIN:  cfg_reg.clamp_min  <= cfg_data;
                REG_CLAMP_MAX:  cfg_reg.clamp_max  <= cfg_data;
                REG_CLAMP_MODE: cfg_reg.clamp_mode <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // output register frees up when empty or being drained
    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    fds_shaper u_shaper (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .burn_state (in_state_reg),
        .demand     (in_demand_reg),
        .state_next (state_next),
        .fan_percent(fan_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{smoothed: '0, enabled: 1'b0, prev_state: ST_IDLE};
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
            if (in_adv)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_state_reg  <= s_tdata[2:0];
            in_demand_reg <= s_tdata[9:3];
        end
        if (in_adv)
            out_pct_reg <= fan_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_pct_reg};

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_pct_reg <= PCT_FULL))
        else $error("fan percent above full scale");

    a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.smoothed <= PCT_FULL)
        else $error("smoothed value above full scale");

    a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.prev_state <= ST_OTHER)
        else $error("stored burn state not folded");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_adv) |-> $stable(state_reg))
        else $error("smoother state moved without a word");

endmodule

[rtl/fds_shaper.sv]
module fds_shaper (
    input  fds_pkg::fds_cfg_t            cfg,
    input  fds_pkg::fds_state_t          state_cur,
    input  logic [fds_pkg::STATE_W-1:0]  burn_state,
    input  logic [fds_pkg::PCT_W-1:0]    demand,
    output fds_pkg::fds_state_t          state_next,
    output logic [fds_pkg::PCT_W-1:0]    fan_percent
);
    import fds_pkg::*;

    logic [STATE_W-1:0] st;
    logic [PCT_W-1:0]   dem;
    logic [PCT_W-1:0]   mn;
    logic [PCT_W-1:0]   mx;
    logic [PCT_W-1:0]   s0;
    logic               e0;
    logic [PCT_W+1:0]   acc;
    logic [PCT_W-1:0]   sm;
    logic [PCT_W-1:0]   fan;
    logic               en;

    always_comb
    begin
        st  = (burn_state > ST_OTHER) ? ST_OTHER : burn_state;
        dem = sat_pct(demand);
        mn  = sat_pct(cfg.clamp_min);
        mx  = sat_pct(cfg.clamp_max);

        s0 = state_cur.smoothed;
        e0 = state_cur.enabled;
        // entry into idle, boost or safety resets the smoother; entry into ramp preloads it
        if (st != state_cur.prev_state)
        begin
            if (st == ST_IDLE || st == ST_BOOST || st == ST_SAFETY)
            begin
                s0 = '0;
                e0 = 1'b0;
            end
            else if (st == ST_RAMP)
            begin
                s0 = mx;
                e0 = 1'b1;
            end
        end

        acc = {1'b0, s0, 1'b0} + {2'b00, s0} + {2'b00, dem};
        sm  = acc[PCT_W+1:2];
        fan = (sm > mx) ? mx : sm;
        en  = e0;

        if (cfg.clamp_mode)
        begin
            en = 1'b1;
        end
        else
        begin
            if (!en && ({1'b0, sm} > ({1'b0, mn} + ON_MARGIN)))
                en = 1'b1;
            if (en && (sm < OFF_LEVEL))
                en = 1'b0;
        end

        if (!en)
            fan = '0;
        else if (fan < mn)
            fan = mn;

        state_next.prev_state = st;
        priority if (st == ST_SAFETY)
        begin
            state_next.smoothed = '0;
            state_next.enabled  = 1'b0;
            fan_percent         = '0;
        end
        else if (st == ST_BOOST)
        begin
            state_next.smoothed = PCT_FULL;
            state_next.enabled  = 1'b1;
            fan_percent         = PCT_FULL;
        end
        else
        begin
            state_next.smoothed = sm;
            state_next.enabled  = en;
            fan_percent         = fan;
        end
    end

endmodule

[tb/sv/tb_fan_demand_shaper_unit.sv]
`timescale 1ns / 100ps

module tb_fan_demand_shaper_unit;
    import fds_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Own copy of the shaper state and registers; one expected fan percent per input word.
    class fan_pct_scoreboard;
        logic [PCT_W-1:0]   cfg_min;
        logic [PCT_W-1:0]   cfg_max;
        logic               cfg_mode;
        logic [PCT_W-1:0]   smooth;
        logic               fan_on;
        logic [STATE_W-1:0] last_state;
        logic [PCT_W-1:0]   fan_q[$];
        int                 n_checked;
        int                 n_errors;

        function new();
            cfg_min    = CLAMP_MIN_RST;
            cfg_max    = CLAMP_MAX_RST;
            cfg_mode   = 1'b1;
            smooth     = '0;
            fan_on     = 1'b0;
            last_state = ST_IDLE;
            n_checked  = 0;
            n_errors   = 0;
        endfunction

        static function int cap_pct(input logic [PCT_W-1:0] v);
            return (v > PCT_FULL) ? int'(PCT_FULL) : int'(v);
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] val);
            case (idx)
                REG_CLAMP_MIN:  cfg_min  = val;
                REG_CLAMP_MAX:  cfg_max  = val;
                REG_CLAMP_MODE: cfg_mode = val[0];
                default: ;
            endcase
        endfunction

        function void note_word(input logic [STATE_W-1:0] st_in, input logic [PCT_W-1:0] dem_in);
            logic [STATE_W-1:0] st;
            int dem;
            int mn;
            int mx;
            int sm;
            int fan;
            st  = (st_in > ST_OTHER) ? ST_OTHER : st_in;
            dem = cap_pct(dem_in);
            mn  = cap_pct(cfg_min);
            mx  = cap_pct(cfg_max);
            if (st != last_state)
            begin
                if (st == ST_BOOST || st == ST_IDLE || st == ST_SAFETY)
                begin
                    smooth = '0;
                    fan_on = 1'b0;
                end
                if (st == ST_RAMP)
                begin
                    smooth = 7'(mx);
                    fan_on = 1'b1;
                end
                last_state = st;
            end
            if (st == ST_SAFETY)
            begin
                smooth = '0;
                fan_on = 1'b0;
                fan    = 0;
            end
            else if (st == ST_BOOST)
            begin
                smooth = PCT_FULL;
                fan_on = 1'b1;
                fan    = PCT_FULL;
            end
            else
            begin
                sm     = (int'(smooth) * 3 + dem) / 4;
                smooth = 7'(sm);
                fan    = (sm > mx) ? mx : sm;
                if (cfg_mode)
                begin
                    if (fan < mn)
                        fan = mn;
                    fan_on = 1'b1;
                end
                else
                begin
                    // on test first, then off test, same tick
                    if (!fan_on && sm > mn + ON_MARGIN)
                        fan_on = 1'b1;
                    if (fan_on && sm < OFF_LEVEL)
                        fan_on = 1'b0;
                end
                if (!fan_on)
                    fan = 0;
                else if (fan < mn)
                    fan = mn;
            end
            fan_q.push_back(7'(fan));
        endfunction

        function void check_word(input logic [PCT_W-1:0] got);
            logic [PCT_W-1:0] want;
            if (fan_q.size() == 0)
            begin
                $display("%0t: fan word with nothing expected: expected none, actual %0d",
                         $time, got);
                n_errors++;
                return;
            end
            want = fan_q.pop_front();
            n_checked++;
            if (got !== want)
            begin
                $display("%0t: fan_percent mismatch: expected %0d, actual %0d",
                         $time, want, got);
                n_errors++;
            end
        endfunction

        function int outstanding();
            return fan_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;   // [2:0] burn_state, [9:3] demand
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;        // [6:0] fan_percent
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PCT_W-1:0]     cfg_data = '0;

    logic hold_rx = 1'b0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;
    int   n_settings = 0;

    fan_pct_scoreboard sb = new();

    fan_demand_shaper_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata[2:0], s_tdata[9:3]);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata[6:0]);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d fan words outstanding",
                     $time, WATCHDOG_LIMIT, sb.outstanding());
            $display("tb_fan_demand_shaper_unit: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(input logic [STATE_W-1:0] st, input logic [PCT_W-1:0] dem);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, dem, st};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering words and wait until every expected fan word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [PCT_W-1:0] mn, input logic [PCT_W-1:0] mx,
                            input logic mode);
        write_reg(REG_CLAMP_MIN, mn);
        write_reg(REG_CLAMP_MAX, mx);
        write_reg(REG_CLAMP_MODE, {6'b0, mode});
        n_settings++;
    endtask

    // Runs of one burn state with random demand; some runs use any code, 5..7 included.
    task automatic run_random(input int n_words);
        int sent;
        int pick;
        int run_len;
        logic [STATE_W-1:0] st;
        logic [PCT_W-1:0]   dem;
        sent = 0;
        while (sent < n_words)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                st = ST_OTHER;
            else if (pick < 55)
                st = ST_RAMP;
            else if (pick < 68)
                st = ST_IDLE;
            else if (pick < 80)
                st = ST_BOOST;
            else if (pick < 90)
                st = ST_SAFETY;
            else
                st = 3'($urandom_range(7));
            run_len = $urandom_range(1, 12);
            repeat (run_len)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    dem = 7'($urandom_range(127));
                else if (pick < 65)
                    dem = 7'($urandom_range(12));
                else if (pick < 85)
                    dem = 7'($urandom_range(127, 85));
                else
                    dem = 7'($urandom_range(60, 20));
                send_word(st, dem);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clamp mode at reset values: saturation, ramp preload, overrides, codes above other
        send_word(ST_IDLE, 7'd0);
        send_word(ST_IDLE, 7'd127);
        send_word(ST_RAMP, 7'd0);
        send_word(ST_RAMP, 7'd100);
        send_word(ST_OTHER, 7'd50);
        for (int k = 1; k <= 3; k++)
            send_word(3'(ST_OTHER + k), (k == 3) ? 7'd127 : 7'd0);
        send_word(ST_BOOST, 7'd0);
        send_word(ST_BOOST, 7'd127);
        send_word(ST_OTHER, 7'd0);
        send_word(ST_SAFETY, 7'd100);
        send_word(ST_SAFETY, 7'd0);
        send_word(ST_OTHER, 7'd101);
        wait_idle();

        // hysteresis: decay below the off level, then climb past min + 10
        set_regs(7'd20, 7'd60, 1'b0);
        write_reg(REG_UNUSED, 7'($urandom_range(127)));
        send_word(ST_RAMP, 7'd0);
        repeat (7) send_word(ST_OTHER, 7'd0);
        repeat (4) send_word(ST_OTHER, 7'd127);
        wait_idle();

        // long receiver hold-off while the sender keeps offering
        idle_pct  = 0;
        stall_pct = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx <= 1'b0;
            end
            run_random(60);
        join
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_regs(7'd20, 7'd100, 1'b1);
                1: set_regs(7'd0, 7'd100, 1'b0);
                2: set_regs(7'd100, 7'd100, 1'b1);
                3: set_regs(7'd0, 7'd0, 1'b0);
                4: set_regs(7'd127, 7'd127, 1'b0);
                5: set_regs(7'd40, 7'd30, 1'b0);
                6: set_regs(7'd35, 7'd110, 1'b1);
                default: set_regs(7'($urandom_range(127)), 7'($urandom_range(127)),
                                  1'($urandom_range(1)));
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            run_random(230);
            wait_idle();
        end

        $display("Checked %0d fan words over %0d register settings (clamp and hysteresis,",
                 sb.n_checked, n_settings);
        $display("min above max, out-of-range registers and codes, idle gaps, backpressure)");
        if (sb.n_errors == 0 && sb.outstanding() == 0)
            $display("tb_fan_demand_shaper_unit: PASS");
        else
            $display("tb_fan_demand_shaper_unit: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/fds_pkg.sv
rtl/fds_shaper.sv
rtl/fan_demand_shaper_unit.sv
tb/sv/tb_fan_demand_shaper_unit.sv
